// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the Laplacian filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lapf_pkg.sv =====
// Types and constants of the Laplacian 3x3 filter block.
package lapf_pkg;

	localparam int PIX_W   = 16;
	localparam int OUT_W   = 15;
	localparam int CFG_W   = 10;
	localparam int IDX_W   = 2;
	localparam int TOT_W   = 2 * CFG_W;
	localparam int POS_W   = TOT_W + 1;
	localparam int SUM_W   = PIX_W + 5;
	localparam int ROWS_RST = 512;

	localparam logic [IDX_W-1:0] REG_SLICE_COLS = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLICE_ROWS = 2'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic signed [PIX_W-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] filtered;
		logic             last_of_slice;
	} out_item_t;

	// Which neighbor taps lie inside the slice, plus output flags.
	typedef struct packed {
		logic out_en;
		logic last;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} tap_ctl_t;

endpackage

// ===== hw/rtl/lapf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module lapf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/laplacian_3x3_filter_clamp_unit.sv =====
// Streaming 3x3 Laplacian filter with zero padding and clamp to 0..32767.
//
// Pixels of a slice enter in raster order on in_valid/in_ready; cmd selects a
// pixel sample or a drain tick. Result item k is produced by the acceptance of
// input item k+cols+1, so after the last pixel of a slice the source sends
// cols+1 drain ticks to flush the last outputs; last_of_slice marks the final
// one. Drain ticks sent while pixels are still due are accepted and dropped.
// Throughput is one item per clock while the receiver does not stall: the two
// line stores share one RAM that is read when an item enters and written back
// as it leaves stage 1, with forwarding when the next item hits the same
// column. A result passes stage 1 and the window into the out_data register.
// Geometry is written through cfg_we/cfg_index/cfg_data while the block is
// idle; a write restarts the slice. Column counts of zero act as one and
// counts above MAX_COLS act as MAX_COLS; a row count of zero acts as one.
// Reset clears the geometry to 512x512 (columns capped at MAX_COLS) and the
// slice positions; no clearing pass runs, since stale line store entries only
// feed padded taps. A stalled receiver holds the output register and, once
// stage 1 and the window are full, drops in_ready combinationally.
`include "assert_macros.svh"

module laplacian_3x3_filter_clamp_unit #(
	parameter int MAX_COLS = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lapf_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lapf_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [lapf_pkg::IDX_W-1:0]       cfg_index,
	input  logic [lapf_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW       = $clog2(MAX_COLS);
	localparam int PW       = lapf_pkg::PIX_W;
	localparam int CW       = lapf_pkg::CFG_W;
	localparam int PSW      = lapf_pkg::POS_W;
	localparam int SW       = lapf_pkg::SUM_W;
	localparam int COLS_RST = (512 > MAX_COLS) ? MAX_COLS : 512;
	localparam int TOT_RST  = COLS_RST * lapf_pkg::ROWS_RST;
	localparam int SAT_MAX  = (1 << lapf_pkg::OUT_W) - 1;

	// geometry
	logic [CW-1:0]                 cols_q;
	logic [CW-1:0]                 rows_q;
	logic [lapf_pkg::TOT_W-1:0]    total_q;
	logic [CW-1:0]                 cfg_cols;
	logic [CW-1:0]                 cfg_rows;
	logic                          cfg_restart;

	// input side positions
	logic [PSW-1:0]                k_q;
	logic [AW-1:0]                 ic_q;
	logic [AW-1:0]                 ocol_q;
	logic [CW-1:0]                 orow_q;

	logic                          in_acc;
	logic                          draining;
	logic                          ignore;
	logic                          take;
	logic                          col_wrap;
	logic                          ocol_wrap;
	logic signed [PW-1:0]          val_in;
	lapf_pkg::tap_ctl_t            ctl_in;

	// stage 1: line store read data arrives
	logic                          v_s1;
	logic signed [PW-1:0]          val_s1;
	logic [AW-1:0]                 addr_s1;
	lapf_pkg::tap_ctl_t            ctl_s1;
	logic                          fwd_s1;
	logic [2*PW-1:0]               fwd_data_s1;
	logic [2*PW-1:0]               ram_rdata;
	logic [2*PW-1:0]               rd_data;
	logic signed [PW-1:0]          top_s1;
	logic signed [PW-1:0]          mid_s1;
	logic                          s1_go;

	// stage 2: window holds the neighborhood of the output pixel
	logic                          v_s2;
	lapf_pkg::tap_ctl_t            ctl_s2;
	logic signed [PW-1:0]          win_q [9];
	logic                          s2_go;
	logic signed [SW-1:0]          sum;
	logic [lapf_pkg::OUT_W-1:0]    clamped;

	logic                          out_valid_q;
	lapf_pkg::out_item_t           out_data_q;

	// ---------------- configuration ----------------
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cols = CW'(1);
		end else if (32'(cfg_data) > MAX_COLS) begin
			cfg_cols = CW'(MAX_COLS);
		end else begin
			cfg_cols = cfg_data;
		end
		cfg_rows = (cfg_data == '0) ? CW'(1) : cfg_data;
	end

	// writes to unused indexes leave the slice running
	assign cfg_restart = cfg_we &&
		(cfg_index inside {lapf_pkg::REG_SLICE_COLS, lapf_pkg::REG_SLICE_ROWS});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= CW'(COLS_RST);
			rows_q  <= CW'(lapf_pkg::ROWS_RST);
			total_q <= lapf_pkg::TOT_W'(TOT_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lapf_pkg::REG_SLICE_COLS: begin
					cols_q  <= cfg_cols;
					total_q <= lapf_pkg::TOT_W'(cfg_cols) * lapf_pkg::TOT_W'(rows_q);
				end
				lapf_pkg::REG_SLICE_ROWS: begin
					rows_q  <= cfg_rows;
					total_q <= lapf_pkg::TOT_W'(cols_q) * lapf_pkg::TOT_W'(cfg_rows);
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- input side ----------------
	assign in_acc   = in_valid && in_ready;
	assign draining = k_q >= PSW'(total_q);
	// drop drain ticks that arrive while pixels are still due
	assign ignore   = (in_data.cmd == lapf_pkg::CMD_DRAIN) && !draining;
	assign take     = in_acc && !ignore;
	assign val_in   = draining ? '0 : in_data.pixel;
	assign col_wrap = (32'(ic_q) + 32'd1) == 32'(cols_q);
	assign ocol_wrap = (32'(ocol_q) + 32'd1) == 32'(cols_q);

	always_comb begin
		ctl_in.out_en   = k_q >= (PSW'(cols_q) + PSW'(1));
		ctl_in.last     = ctl_in.out_en && (k_q == PSW'(total_q) + PSW'(cols_q));
		ctl_in.top_ok   = orow_q != '0;
		ctl_in.bot_ok   = (32'(orow_q) + 32'd1) < 32'(rows_q);
		ctl_in.left_ok  = ocol_q != '0;
		ctl_in.right_ok = !ocol_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			ic_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_restart) begin
			k_q    <= '0;
			ic_q   <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (ctl_in.last) begin
				k_q    <= '0;
				ic_q   <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				k_q  <= k_q + PSW'(1);
				ic_q <= col_wrap ? '0 : ic_q + AW'(1);
				if (ctl_in.out_en) begin
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + CW'(1);
					end else begin
						ocol_q <= ocol_q + AW'(1);
					end
				end
			end
		end
	end

	// ---------------- pipeline control ----------------
	assign s2_go    = v_s2 && (!out_valid_q || out_ready);
	assign s1_go    = v_s1 && (!v_s2 || s2_go);
	assign in_ready = !v_s1 || s1_go;

	// ---------------- line store ----------------
	// entry = {upper row, lower row} of one column
	lapf_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_COLS)
	) u_row_store (
		.clk   (clk),
		.we    (s1_go),
		.waddr (addr_s1),
		.wdata ({mid_s1, val_s1}),
		.re    (take),
		.raddr (ic_q),
		.rdata (ram_rdata)
	);

	assign rd_data = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign top_s1  = rd_data[2*PW-1:PW];
	assign mid_s1  = rd_data[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
			// the item ahead writes this column in the same cycle
			fwd_s1 <= v_s1 && (addr_s1 == ic_q);
		end else if (s1_go) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			val_s1      <= val_in;
			addr_s1     <= ic_q;
			ctl_s1      <= ctl_in;
			fwd_data_s1 <= {mid_s1, val_s1};
		end
	end

	// ---------------- window ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= top_s1;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_s1;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_go) begin
			v_s2 <= ctl_s1.out_en;
		end else if (s2_go) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// ---------------- filter and clamp ----------------
	always_comb begin
		logic row_ok;
		logic col_ok;
		sum = SW'(win_q[4]) <<< 3;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				row_ok = (r == 1) || (r == 0 && ctl_s2.top_ok) || (r == 2 && ctl_s2.bot_ok);
				col_ok = (c == 1) || (c == 0 && ctl_s2.left_ok) || (c == 2 && ctl_s2.right_ok);
				if (!(r == 1 && c == 1) && row_ok && col_ok) begin
					sum = sum - SW'(win_q[r*3+c]);
				end
			end
		end
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > SW'(SAT_MAX)) begin
			clamped = lapf_pkg::OUT_W'(SAT_MAX);
		end else begin
			clamped = sum[lapf_pkg::OUT_W-1:0];
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_data_q.filtered      <= clamped;
			out_data_q.last_of_slice <= ctl_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- assertions ----------------
	`ASSERT_IMP(a_fwd_has_writer, clk, arst_n, fwd_s1, v_s1,
		"forward flag set with no item in stage 1")
	`ASSERT_IMP(a_accept_moves_s1, clk, arst_n, in_acc && v_s1, s1_go,
		"item accepted while stage 1 stalls")
	`ASSERT_IMP(a_col_in_range, clk, arst_n, 1'b1, 32'(ic_q) < 32'(cols_q),
		"input column beyond slice width")
	`ASSERT_IMP(a_pos_bound, clk, arst_n, 1'b1,
		k_q <= PSW'(total_q) + PSW'(cols_q),
		"input position past the end of the drain")

endmodule
